// ===== design/vgsd_pkg.sv =====
`timescale 1ns / 1ps
package vgsd_pkg;

	localparam int GRID_SIDE  = 64;
	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int SIDE_W     = $clog2(GRID_SIDE + 1);

	// shared divider and square root widths
	localparam int DIV_NW = 40;
	localparam int DIV_DW = 24;
	localparam int DIV_CW = $clog2(DIV_NW);
	localparam int SQ_VW  = 48;
	localparam int SQ_RW  = 24;

	localparam logic [1:0] REQ_DECAY  = 2'd0;
	localparam logic [1:0] REQ_INJECT = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [1:0] REG_ORIGIN_X  = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y  = 2'd1;
	localparam logic [1:0] REG_CELL_SIZE = 2'd2;

	localparam logic [15:0] ORIGIN_RESET    = 16'hFB00;
	localparam logic [14:0] CELL_SIZE_RESET = 15'd256;

	localparam logic [13:0] DECAY_Q14   = 14'd16220;
	localparam logic [15:0] STEP_SCALED = 16'd41984;
	localparam logic [31:0] UNIT_SQ     = 32'h1000_0000;

endpackage

// ===== design/vgsd_req_if.sv =====
`timescale 1ns / 1ps
interface vgsd_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic signed [15:0] box_min_x;
	logic signed [15:0] box_min_y;
	logic signed [15:0] box_max_x;
	logic signed [15:0] box_max_y;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	logic [11:0]       cell_index;

	modport source (output valid, req_type, box_min_x, box_min_y, box_max_x, box_max_y,
		dir_x, dir_y, cell_index, input ready);
	modport sink (input valid, req_type, box_min_x, box_min_y, box_max_x, box_max_y,
		dir_x, dir_y, cell_index, output ready);
endinterface

// ===== design/vgsd_rsp_if.sv =====
`timescale 1ns / 1ps
interface vgsd_rsp_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic [12:0]       cells_touched;

	modport source (output valid, kind, vel_x, vel_y, cells_touched, input ready);
	modport sink (input valid, kind, vel_x, vel_y, cells_touched, output ready);
endinterface

// ===== design/vgsd_cfg_if.sv =====
`timescale 1ns / 1ps
interface vgsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/vgsd_div.sv =====
`timescale 1ns / 1ps
module vgsd_div import vgsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo,
	output logic [DIV_DW-1:0] rem
);
	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule

// ===== design/vgsd_isqrt.sv =====
`timescale 1ns / 1ps
module vgsd_isqrt import vgsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_VW-1:0] value,
	output logic             done,
	output logic [SQ_RW-1:0] root
);
	logic             busy_q;
	logic             done_q;
	logic [SQ_VW-1:0] n_q;
	logic [SQ_VW-1:0] res_q;
	logic [SQ_VW-1:0] bit_q;
	logic [SQ_VW-1:0] sum;
	logic             ge;

	// digit by digit root, one result bit per cycle
	assign sum = res_q + bit_q;
	assign ge  = n_q >= sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= value;
				res_q  <= '0;
				bit_q  <= {2'b01, {(SQ_VW - 2){1'b0}}};
			end else if (busy_q) begin
				if (ge) begin
					n_q   <= n_q - sum;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = res_q[SQ_RW-1:0];
endmodule

// ===== design/velocity_grid_splat_decay.sv =====
`timescale 1ns / 1ps
// read: one registered grid memory read; decay tick: one cell per cycle through the grid memory
// inject: four bound divisions, a root and two step divisions, then per covered cell a read,
// add, square, compare, write; renormalizing adds a root and two divisions on the shared units
// one item at a time; the next item is taken while the last result waits at the output
// after reset the grid memory is swept to zero, and no item is taken until the sweep is done
module velocity_grid_splat_decay import vgsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	vgsd_req_if.sink   req,
	vgsd_rsp_if.source rsp,
	vgsd_cfg_if.sink   cfg
);
	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DEC, S_DEC_LAST, S_BND, S_BND_W, S_SQ, S_LEN, S_LEN_W,
		S_STEP, S_STEP_W, S_CHK, S_CELL_RD, S_CELL_DAT, S_CELL_SQ, S_CELL_CMP,
		S_NRM_LEN_W, S_NRM_DIV, S_NRM_DIV_W, S_CELL_WR, S_RD_WAIT, S_DONE
	} state_t;

	state_t state_q;

	logic [15:0] origin_x_q, origin_y_q;
	logic [14:0] cell_size_q;

	logic [1:0]  kind_q;
	logic [15:0] bmin_x_q, bmin_y_q, bmax_x_q, bmax_y_q, dx_q, dy_q;
	logic [1:0]  k_q;
	logic [CELL_W-1:0] cnt_q;
	logic [SIDE_W-1:0] x0_q, y0_q, x1_q, y1_q, cx_q, cy_q;
	logic [SQ_RW-1:0]  len_q;
	logic [15:0] stx_q, sty_q, nx_q, ny_q;
	logic [30:0] sqx_q, sqy_q;
	logic [15:0] res_vx_q, res_vy_q;
	logic [12:0] touched_q;
	logic        rd_ok_q;

	logic        rsp_valid_q;
	logic [1:0]  rsp_kind_q;
	logic [15:0] rsp_vx_q, rsp_vy_q;
	logic [12:0] rsp_touched_q;

	logic              dec_v_s1;
	logic [CELL_W-1:0] dec_addr_s1;

	logic [31:0] mem [CELL_COUNT];
	logic [31:0] rdata_q;
	logic              mem_we;
	logic [CELL_W-1:0] mem_waddr, mem_raddr, cell_addr;
	logic [31:0]       mem_wdata;

	function automatic logic [15:0] decay16(input logic [15:0] v);
		logic [16:0] mag;
		logic [30:0] p;
		logic [16:0] m2;
		begin
			mag = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
			p   = mag * DECAY_Q14;
			m2  = p[30:14];
			decay16 = v[15] ? 16'(17'd0 - m2) : m2[15:0];
		end
	endfunction

	function automatic logic [15:0] sat18(input logic [17:0] s);
		logic signed [17:0] v;
		begin
			v = s;
			if (v > 18'sd32767) sat18 = 16'h7FFF;
			else if (v < -18'sd32768) sat18 = 16'h8000;
			else sat18 = s[15:0];
		end
	endfunction

	// sign and magnitude quotient into a saturated 16-bit value
	function automatic logic [15:0] sat_sm(input logic neg, input logic [DIV_NW-1:0] q);
		begin
			if (!neg) sat_sm = (q > DIV_NW'(32767)) ? 16'h7FFF : q[15:0];
			else sat_sm = (q > DIV_NW'(32768)) ? 16'h8000 : 16'(16'd0 - q[15:0]);
		end
	endfunction

	// shared arithmetic units
	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den, div_rem;
	logic              sq_start, sq_done;
	logic [SQ_VW-1:0]  sq_value;
	logic [SQ_RW-1:0]  sq_root;

	vgsd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	vgsd_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(sq_value),
		.done(sq_done), .root(sq_root)
	);

	// operand selection
	logic [14:0] cs_eff;
	logic [15:0] coord, orig;
	logic [16:0] a_diff, a_mag;
	logic        a_neg;
	logic [15:0] d_sel, d_mag, n_sel, n_mag;
	logic [31:0] step_prod;
	logic [31:0] s_sum;
	logic [15:0] sq_a, sq_b;
	logic signed [31:0] sq_pa, sq_pb;
	logic [18:0] qs, bnd;
	logic [SIDE_W-1:0] bnd_c;
	logic [17:0] add_x, add_y;

	assign cs_eff = (cell_size_q == '0) ? 15'd1 : cell_size_q;

	always_comb begin
		case (k_q)
			2'd0:    begin coord = bmin_x_q; orig = origin_x_q; end
			2'd1:    begin coord = bmin_y_q; orig = origin_y_q; end
			2'd2:    begin coord = bmax_x_q; orig = origin_x_q; end
			default: begin coord = bmax_y_q; orig = origin_y_q; end
		endcase
	end

	assign a_diff = {coord[15], coord} - {orig[15], orig};
	assign a_neg  = a_diff[16];
	assign a_mag  = a_neg ? (17'd0 - a_diff) : a_diff;

	assign d_sel     = k_q[0] ? dy_q : dx_q;
	assign d_mag     = d_sel[15] ? (16'd0 - d_sel) : d_sel;
	assign step_prod = d_mag * STEP_SCALED;
	assign n_sel     = k_q[0] ? ny_q : nx_q;
	assign n_mag     = n_sel[15] ? (16'd0 - n_sel) : n_sel;

	always_comb begin
		div_start = 1'b0;
		div_num   = DIV_NW'(a_mag);
		div_den   = DIV_DW'(cs_eff);
		case (state_q)
			S_BND: div_start = 1'b1;
			S_STEP: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(step_prod) + DIV_NW'(len_q >> 1);
				div_den   = len_q;
			end
			S_NRM_DIV: begin
				div_start = 1'b1;
				div_num   = DIV_NW'({n_mag, 22'd0}) + DIV_NW'(len_q >> 1);
				div_den   = len_q;
			end
			default: ;
		endcase
	end

	assign s_sum    = 32'(sqx_q) + 32'(sqy_q);
	assign sq_value = {s_sum, 16'd0};
	assign sq_start = (state_q == S_LEN) || ((state_q == S_CELL_CMP) && (s_sum > UNIT_SQ));

	assign sq_a  = (state_q == S_SQ) ? dx_q : nx_q;
	assign sq_b  = (state_q == S_SQ) ? dy_q : ny_q;
	assign sq_pa = $signed(sq_a) * $signed(sq_a);
	assign sq_pb = $signed(sq_b) * $signed(sq_b);

	// floor for lower bounds, ceil for upper bounds, then clamp to the grid
	assign qs = {2'b00, div_quo[16:0]};
	always_comb begin
		if (!k_q[1]) bnd = a_neg ? (19'd0 - qs - 19'(|div_rem)) : qs;
		else bnd = a_neg ? (19'd0 - qs) : (qs + 19'(|div_rem));
		if (bnd[18]) bnd_c = '0;
		else if (bnd > 19'(GRID_SIDE)) bnd_c = SIDE_W'(GRID_SIDE);
		else bnd_c = bnd[SIDE_W-1:0];
	end

	assign add_x = {{2{rdata_q[15]}}, rdata_q[15:0]} + {{2{stx_q[15]}}, stx_q};
	assign add_y = {{2{rdata_q[31]}}, rdata_q[31:16]} + {{2{sty_q[15]}}, sty_q};

	assign cell_addr = CELL_W'(int'(cy_q) * GRID_SIDE + int'(cx_q));

	// grid memory
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cell_addr;
		mem_wdata = {ny_q, nx_q};
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q;
			mem_wdata = '0;
		end else if (dec_v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = dec_addr_s1;
			mem_wdata = {decay16(rdata_q[31:16]), decay16(rdata_q[15:0])};
		end else if (state_q == S_CELL_WR) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		case (state_q)
			S_IDLE:  mem_raddr = CELL_W'(req.cell_index);
			S_DEC:   mem_raddr = cnt_q;
			default: mem_raddr = cell_addr;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q  <= ORIGIN_RESET;
			origin_y_q  <= ORIGIN_RESET;
			cell_size_q <= CELL_SIZE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ORIGIN_X:  origin_x_q  <= cfg.data;
				REG_ORIGIN_Y:  origin_y_q  <= cfg.data;
				REG_CELL_SIZE: cell_size_q <= cfg.data[14:0];
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			k_q         <= '0;
			dec_v_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			dec_v_s1    <= (state_q == S_DEC);
			dec_addr_s1 <= cnt_q;
			// the done state loads the output register itself
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CELL_W'(CELL_COUNT - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						kind_q    <= req.req_type;
						bmin_x_q  <= req.box_min_x;
						bmin_y_q  <= req.box_min_y;
						bmax_x_q  <= req.box_max_x;
						bmax_y_q  <= req.box_max_y;
						dx_q      <= req.dir_x;
						dy_q      <= req.dir_y;
						rd_ok_q   <= 32'(req.cell_index) < CELL_COUNT;
						res_vx_q  <= '0;
						res_vy_q  <= '0;
						touched_q <= '0;
						k_q       <= '0;
						cnt_q     <= '0;
						case (req.req_type)
							REQ_DECAY: state_q <= S_DEC;
							REQ_INJECT: begin
								if (req.dir_x == '0 && req.dir_y == '0) state_q <= S_DONE;
								else state_q <= S_BND;
							end
							REQ_READ: state_q <= S_RD_WAIT;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_DEC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CELL_W'(CELL_COUNT - 1)) state_q <= S_DEC_LAST;
				end
				S_DEC_LAST: begin
					touched_q <= 13'(CELL_COUNT);
					state_q   <= S_DONE;
				end
				S_BND: state_q <= S_BND_W;
				S_BND_W: begin
					if (div_done) begin
						case (k_q)
							2'd0:    x0_q <= bnd_c;
							2'd1:    y0_q <= bnd_c;
							2'd2:    x1_q <= bnd_c;
							default: y1_q <= bnd_c;
						endcase
						k_q     <= k_q + 1'b1;
						state_q <= (k_q == 2'd3) ? S_SQ : S_BND;
					end
				end
				S_SQ: begin
					sqx_q   <= sq_pa[30:0];
					sqy_q   <= sq_pb[30:0];
					state_q <= S_LEN;
				end
				S_LEN: state_q <= S_LEN_W;
				S_LEN_W: begin
					if (sq_done) begin
						len_q   <= sq_root;
						k_q     <= '0;
						state_q <= S_STEP;
					end
				end
				S_STEP: state_q <= S_STEP_W;
				S_STEP_W: begin
					if (div_done) begin
						if (k_q[0]) sty_q <= sat_sm(d_sel[15], div_quo);
						else stx_q <= sat_sm(d_sel[15], div_quo);
						k_q     <= k_q + 1'b1;
						state_q <= k_q[0] ? S_CHK : S_STEP;
					end
				end
				S_CHK: begin
					cx_q <= x0_q;
					cy_q <= y0_q;
					if (x0_q >= x1_q || y0_q >= y1_q) state_q <= S_DONE;
					else state_q <= S_CELL_RD;
				end
				S_CELL_RD: state_q <= S_CELL_DAT;
				S_CELL_DAT: begin
					nx_q    <= sat18(add_x);
					ny_q    <= sat18(add_y);
					state_q <= S_CELL_SQ;
				end
				S_CELL_SQ: begin
					sqx_q   <= sq_pa[30:0];
					sqy_q   <= sq_pb[30:0];
					state_q <= S_CELL_CMP;
				end
				S_CELL_CMP: state_q <= (s_sum > UNIT_SQ) ? S_NRM_LEN_W : S_CELL_WR;
				S_NRM_LEN_W: begin
					if (sq_done) begin
						len_q   <= sq_root;
						k_q     <= '0;
						state_q <= S_NRM_DIV;
					end
				end
				S_NRM_DIV: state_q <= S_NRM_DIV_W;
				S_NRM_DIV_W: begin
					if (div_done) begin
						if (k_q[0]) ny_q <= sat_sm(n_sel[15], div_quo);
						else nx_q <= sat_sm(n_sel[15], div_quo);
						k_q     <= k_q + 1'b1;
						state_q <= k_q[0] ? S_CELL_WR : S_NRM_DIV;
					end
				end
				S_CELL_WR: begin
					touched_q <= touched_q + 1'b1;
					if (cx_q + 1'b1 == x1_q) begin
						cx_q <= x0_q;
						cy_q <= cy_q + 1'b1;
						state_q <= (cy_q + 1'b1 == y1_q) ? S_DONE : S_CELL_RD;
					end else begin
						cx_q    <= cx_q + 1'b1;
						state_q <= S_CELL_RD;
					end
				end
				S_RD_WAIT: begin
					if (rd_ok_q) begin
						res_vx_q <= rdata_q[15:0];
						res_vy_q <= rdata_q[31:16];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_kind_q    <= kind_q;
						rsp_vx_q      <= res_vx_q;
						rsp_vy_q      <= res_vy_q;
						rsp_touched_q <= touched_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.kind          = rsp_kind_q;
	assign rsp.vel_x         = rsp_vx_q;
	assign rsp.vel_y         = rsp_vy_q;
	assign rsp.cells_touched = rsp_touched_q;

	a_cell_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CELL_WR) |-> (cx_q < x1_q && cy_q < y1_q && cx_q >= x0_q))
		else $error("cell write outside the box bounds");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside the done state");

	a_div_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_start && !div_done)
		else $error("divider restarted or finished too early");
endmodule

// ===== sim/vgsd_checker.sv =====
`timescale 1ns / 1ps
module vgsd_checker import vgsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	vgsd_req_if  req,
	vgsd_rsp_if  rsp,
	vgsd_cfg_if  cfg,
	output int   errors,
	output int   pending
);

	localparam int STEP_Q14 = 164;
	localparam int DECAY_MUL = 16220;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic [12:0]        cells_touched;
	} answer_t;

	answer_t answers_q[$];
	logic [31:0] cells [CELL_COUNT];
	logic signed [15:0] org_x, org_y;
	logic [14:0] csize;

	initial errors = 0;
	assign pending = answers_q.size();

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res + bit_v) begin
				n -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint mag, q;
		mag = num < 0 ? -num : num;
		q = (mag + den / 2) / den;
		return num < 0 ? -q : q;
	endfunction

	function automatic int sat16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	function automatic int fdiv(int a, int b);
		int q;
		q = a / b;
		if (a % b != 0 && a < 0) q--;
		return q;
	endfunction

	function automatic int cdiv(int a, int b);
		int q;
		q = a / b;
		if (a % b != 0 && a > 0) q++;
		return q;
	endfunction

	function automatic int clamp_side(int v);
		if (v < 0) return 0;
		if (v > GRID_SIDE) return GRID_SIDE;
		return v;
	endfunction

	function automatic int decay_val(int v);
		longint p, mag;
		p = longint'(v) * DECAY_MUL;
		mag = (p < 0 ? -p : p) >> 14;
		return int'(p < 0 ? -mag : mag);
	endfunction

	function automatic answer_t predict_answer();
		answer_t a;
		int dx, dy, cs, x0, y0, x1, y1, nx, ny, idx;
		longint len, stx, sty, m;
		longint unsigned s;
		logic signed [15:0] cx, cy;
		a = '0;
		a.kind = req.req_type;
		if (req.req_type == REQ_DECAY) begin
			for (int i = 0; i < CELL_COUNT; i++) begin
				cx = cells[i][15:0];
				cy = cells[i][31:16];
				cells[i] = {16'(decay_val(cy)), 16'(decay_val(cx))};
			end
			a.cells_touched = 13'(CELL_COUNT);
		end else if (req.req_type == REQ_INJECT) begin
			dx = req.dir_x;
			dy = req.dir_y;
			if (dx != 0 || dy != 0) begin
				cs = csize != 0 ? int'(csize) : 1;
				x0 = clamp_side(fdiv(int'(req.box_min_x) - int'(org_x), cs));
				y0 = clamp_side(fdiv(int'(req.box_min_y) - int'(org_y), cs));
				x1 = clamp_side(cdiv(int'(req.box_max_x) - int'(org_x), cs));
				y1 = clamp_side(cdiv(int'(req.box_max_y) - int'(org_y), cs));
				s = longint'(dx) * dx + longint'(dy) * dy;
				len = longint'(root64(s << 16));
				stx = round_div(longint'(dx) * STEP_Q14 * 256, len);
				sty = round_div(longint'(dy) * STEP_Q14 * 256, len);
				for (int y = y0; y < y1; y++) begin
					for (int x = x0; x < x1; x++) begin
						idx = x + y * GRID_SIDE;
						cx = cells[idx][15:0];
						cy = cells[idx][31:16];
						nx = sat16(longint'(cx) + stx);
						ny = sat16(longint'(cy) + sty);
						s = longint'(nx) * nx + longint'(ny) * ny;
						// renormalize cells longer than one
						if (s > 64'h1000_0000) begin
							m = longint'(root64(s << 16));
							nx = sat16(round_div(longint'(nx) * (64'sd1 <<< 22), m));
							ny = sat16(round_div(longint'(ny) * (64'sd1 <<< 22), m));
						end
						cells[idx] = {16'(ny), 16'(nx)};
						a.cells_touched = a.cells_touched + 13'd1;
					end
				end
			end
		end else if (req.req_type == REQ_READ) begin
			if (int'(req.cell_index) < CELL_COUNT) begin
				a.vel_x = cells[req.cell_index][15:0];
				a.vel_y = cells[req.cell_index][31:16];
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		if (!arst_n) begin
			org_x = ORIGIN_RESET;
			org_y = ORIGIN_RESET;
			csize = CELL_SIZE_RESET;
			for (int i = 0; i < CELL_COUNT; i++) cells[i] = '0;
			answers_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (answers_q.size() == 0) begin
					$error("result item with no expectation waiting");
					errors++;
				end else begin
					exp_a = answers_q.pop_front();
					if (rsp.kind !== exp_a.kind) begin
						$error("kind: expected %0d, actual %0d", exp_a.kind, rsp.kind);
						errors++;
					end
					if (rsp.vel_x !== exp_a.vel_x) begin
						$error("vel_x: expected %0d, actual %0d", exp_a.vel_x, rsp.vel_x);
						errors++;
					end
					if (rsp.vel_y !== exp_a.vel_y) begin
						$error("vel_y: expected %0d, actual %0d", exp_a.vel_y, rsp.vel_y);
						errors++;
					end
					if (rsp.cells_touched !== exp_a.cells_touched) begin
						$error("cells_touched: expected %0d, actual %0d",
							exp_a.cells_touched, rsp.cells_touched);
						errors++;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ORIGIN_X: org_x = cfg.data;
					REG_ORIGIN_Y: org_y = cfg.data;
					REG_CELL_SIZE: csize = cfg.data[14:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) answers_q.push_back(predict_answer());
		end
	end

endmodule

// ===== sim/velocity_grid_splat_decay_tb.sv =====
`timescale 1ns / 1ps
module velocity_grid_splat_decay_tb;
	import vgsd_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] REG_NONE   = 2'd3;
	localparam int IDLE_LIMIT = 2000000;
	localparam int HOT_CELL   = 5 + 5 * GRID_SIDE;

	logic clk;
	logic arst_n;
	int   errors, pending;
	int   ox, oy, cs;
	int   idle_cycles;
	int   items_left;
	bit   quiet;
	bit   hold_req;

	vgsd_req_if req_if();
	vgsd_rsp_if rsp_if();
	vgsd_cfg_if cfg_if();

	velocity_grid_splat_decay u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if),
		.cfg   (cfg_if)
	);

	vgsd_checker u_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if),
		.errors (errors),
		.pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				rsp_if.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send(logic [1:0] t, int mnx, int mny, int mxx, int mxy,
		int dx, int dy, int idx);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.req_type  <= t;
		req_if.box_min_x <= 16'(mnx);
		req_if.box_min_y <= 16'(mny);
		req_if.box_max_x <= 16'(mxx);
		req_if.box_max_y <= 16'(mxy);
		req_if.dir_x     <= 16'(dx);
		req_if.dir_y     <= 16'(dy);
		req_if.cell_index <= 12'(idx);
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= 16'(val);
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ORIGIN_X: ox = int'($signed(16'(val)));
			REG_ORIGIN_Y: oy = int'($signed(16'(val)));
			REG_CELL_SIZE: cs = (val & 32'h7FFF) == 0 ? 1 : (val & 32'h7FFF);
			default: ;
		endcase
	endtask

	task automatic inject_cells(int cx, int cy, int w, int h, int dx, int dy);
		int mnx, mny;
		mnx = ox + cx * cs + int'($urandom_range(0, cs - 1));
		mny = oy + cy * cs + int'($urandom_range(0, cs - 1));
		send(REQ_INJECT, mnx, mny, mnx + w * cs + int'($urandom_range(0, cs)),
			mny + h * cs + int'($urandom_range(0, cs)), dx, dy, 0);
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			send(REQ_DECAY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
		else if (r < 30)
			send(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				r < 20 ? HOT_CELL + $urandom_range(0, 3) * GRID_SIDE + $urandom_range(0, 3)
					: $urandom_range(0, CELL_COUNT - 1));
		else if (r < 34)
			send(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
		else if (r < 42)
			send(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
		else if (r < 47)
			inject_cells($urandom_range(0, 67) - 2, $urandom_range(0, 67) - 2, 2, 2, 0, 0);
		else
			inject_cells($urandom_range(0, 67) - 2, $urandom_range(0, 67) - 2,
				$urandom_range(0, 3), $urandom_range(0, 3), $urandom, $urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		quiet = 0;
		hold_req = 0;
		ox = -1280;
		oy = -1280;
		cs = 256;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_DECAY;
		req_if.box_min_x <= '0;
		req_if.box_min_y <= '0;
		req_if.box_max_x <= '0;
		req_if.box_max_y <= '0;
		req_if.dir_x <= '0;
		req_if.dir_y <= '0;
		req_if.cell_index <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= REG_ORIGIN_X;
		cfg_if.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset configuration
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, CELL_COUNT - 1);
		send(REQ_UNUSED, -1, -1, -1, -1, -1, -1, 12'hFFF);
		send(REQ_INJECT, 0, 0, 128, 128, 0, 0, 0);
		send(REQ_INJECT, 0, 0, 128, 128, 32767, -32768, 0);
		send(REQ_INJECT, -32768, -32768, 32767, 32767, -32768, 32767, 0);
		send(REQ_INJECT, 512, 512, 0, 0, 256, 256, 0);
		send(REQ_INJECT, -32768, 32767, 32767, -32768, 1, 1, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, HOT_CELL);
		send(REQ_DECAY, 0, 0, 0, 0, 0, 0, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, HOT_CELL);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, CELL_COUNT - 1);

		// pile items onto one cell, nearly along x, until it must be renormalized
		for (int i = 0; i < 104; i++) begin
			if (i == 10) hold_req = 1;
			send(REQ_INJECT, 0, 0, 128, 128, $urandom_range(16384, 32767),
				$urandom_range(0, 1000), 0);
		end
		send(REQ_READ, 0, 0, 0, 0, 0, 0, HOT_CELL);
		send(REQ_DECAY, 0, 0, 0, 0, 0, 0, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, HOT_CELL);
		drain();

		// extreme configurations
		write_reg(REG_NONE, 16'h1234);
		write_reg(REG_ORIGIN_X, -32768);
		write_reg(REG_ORIGIN_Y, -32768);
		write_reg(REG_CELL_SIZE, 1);
		send(REQ_INJECT, -32768, -32768, -32765, -32766, -300, 700, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 1 + GRID_SIDE);
		drain();
		write_reg(REG_CELL_SIZE, 0);
		send(REQ_INJECT, -32760, -32766, -32758, -32764, 5, -5, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 8 + 2 * GRID_SIDE);
		drain();
		write_reg(REG_ORIGIN_X, 32767);
		write_reg(REG_ORIGIN_Y, 32767);
		write_reg(REG_CELL_SIZE, 32767);
		send(REQ_INJECT, -32768, -32768, 32767, 32767, 100, 100, 0);
		send(REQ_INJECT, 32767, 32767, -32768, -32768, 100, 100, 0);
		send(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
		drain();

		// random, finer grid
		write_reg(REG_ORIGIN_X, -2560);
		write_reg(REG_ORIGIN_Y, -2560);
		write_reg(REG_CELL_SIZE, 128);
		for (int i = 0; i < 8; i++) random_item();
		drain();

		// random, reset configuration again, no stalls at the end
		write_reg(REG_ORIGIN_X, -1280);
		write_reg(REG_ORIGIN_Y, -1280);
		write_reg(REG_CELL_SIZE, 256);
		for (int i = 0; i < 10; i++) begin
			if (i == 5) quiet = 1;
			random_item();
		end
		req_if.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
